@@ sv/elga_pkg.sv @@
// Package: types, constants and codes shared by the embedding table block.
package elga_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_DIM  = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_DIM);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = MAX_ROWS * MAX_DIM;
    localparam int CNT_W    = COL_W + 1;
    localparam int RCMP_W   = 17;

    localparam logic [2:0] OP_LOAD_W   = 3'd0;
    localparam logic [2:0] OP_LOOKUP   = 3'd1;
    localparam logic [2:0] OP_ACC_G    = 3'd2;
    localparam logic [2:0] OP_READ_W   = 3'd3;
    localparam logic [2:0] OP_READ_G   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_PAD      = 2'd2;

    localparam logic [1:0] CFG_ROWS    = 2'd0;
    localparam logic [1:0] CFG_DIM     = 2'd1;
    localparam logic [1:0] CFG_PAD_EN  = 2'd2;
    localparam logic [1:0] CFG_PAD_ROW = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] row_index;
        logic [5:0]         column;
        logic [31:0]        value_bits;
    } req_t;

    typedef struct packed {
        logic [31:0] data_bits;
        logic [5:0]  element_pos;
        logic        last;
        logic [1:0]  status;
    } res_t;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } fadd_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] sum;
    } fadd_res_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_LOOKUP,
        S_GRAD_RD,
        S_FP_WAIT
    } state_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ALIGN,
        F_ADD,
        F_NORM,
        F_ROUND,
        F_DONE
    } fstate_t;

endpackage

@@ sv/elga_ram.sv @@
// Generic single-port RAM with registered read.
module elga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/elga_fadd.sv @@
// Multi-cycle float32 adder, round to nearest even, bit-serial normalization.
module elga_fadd (
    input  logic                clk,
    input  logic                rst_n,
    input  elga_pkg::fadd_req_t req,
    output elga_pkg::fadd_res_t res
);

    elga_pkg::fstate_t st_reg, st_next;
    logic        sign_reg, sign_next;
    logic        sub_reg, sub_next;
    logic [9:0]  e_reg, e_next;
    logic [7:0]  d_reg, d_next;
    logic [26:0] ma_reg, ma_next;
    logic [26:0] mb_reg, mb_next;
    logic [31:0] out_reg, out_next;

    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        nan_a, nan_b, inf_a, inf_b, a_big;
    logic [26:0] mska, mskb, mask;
    logic [27:0] sum;
    logic        up;
    logic [24:0] mant;
    logic [9:0]  ef;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= elga_pkg::F_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        sub_reg  <= sub_next;
        e_reg    <= e_next;
        d_reg    <= d_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        st_next   = st_reg;
        sign_next = sign_reg;
        sub_next  = sub_reg;
        e_next    = e_reg;
        d_next    = d_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        out_next  = out_reg;
        ea    = req.a[30:23];
        eb    = req.b[30:23];
        fa    = req.a[22:0];
        fb    = req.b[22:0];
        nan_a = (ea == 8'hFF) && (fa != 23'd0);
        nan_b = (eb == 8'hFF) && (fb != 23'd0);
        inf_a = (ea == 8'hFF) && (fa == 23'd0);
        inf_b = (eb == 8'hFF) && (fb == 23'd0);
        a_big = req.a[30:0] >= req.b[30:0];
        mska  = {(ea != 8'd0), fa, 3'b000};
        mskb  = {(eb != 8'd0), fb, 3'b000};
        mask  = ~(27'h7FF_FFFF << d_reg[4:0]);
        sum   = sub_reg ? ({1'b0, ma_reg} - {1'b0, mb_reg})
                        : ({1'b0, ma_reg} + {1'b0, mb_reg});
        up    = ma_reg[2] && (ma_reg[1] || ma_reg[0] || ma_reg[3]);
        mant  = {1'b0, ma_reg[26:3]} + {24'd0, up};
        ef    = 10'd0;
        res.done = (st_reg == elga_pkg::F_DONE);
        res.sum  = out_reg;

        unique case (st_reg)
            elga_pkg::F_IDLE:
            begin
                if (req.start)
                begin
                    // NaNs come back quieted, first operand wins
                    if (nan_a)
                    begin
                        out_next = req.a | 32'h0040_0000;
                        st_next  = elga_pkg::F_DONE;
                    end
                    else if (nan_b)
                    begin
                        out_next = req.b | 32'h0040_0000;
                        st_next  = elga_pkg::F_DONE;
                    end
                    else if (inf_a && inf_b && (req.a[31] != req.b[31]))
                    begin
                        out_next = 32'hFFC0_0000;
                        st_next  = elga_pkg::F_DONE;
                    end
                    else if (inf_a)
                    begin
                        out_next = req.a;
                        st_next  = elga_pkg::F_DONE;
                    end
                    else if (inf_b)
                    begin
                        out_next = req.b;
                        st_next  = elga_pkg::F_DONE;
                    end
                    else
                    begin
                        sub_next = req.a[31] ^ req.b[31];
                        if (a_big)
                        begin
                            sign_next = req.a[31];
                            ma_next   = mska;
                            mb_next   = mskb;
                            e_next    = {2'b00, (ea == 8'd0) ? 8'd1 : ea};
                            d_next    = ((ea == 8'd0) ? 8'd1 : ea)
                                      - ((eb == 8'd0) ? 8'd1 : eb);
                        end
                        else
                        begin
                            sign_next = req.b[31];
                            ma_next   = mskb;
                            mb_next   = mska;
                            e_next    = {2'b00, (eb == 8'd0) ? 8'd1 : eb};
                            d_next    = ((eb == 8'd0) ? 8'd1 : eb)
                                      - ((ea == 8'd0) ? 8'd1 : ea);
                        end
                        st_next = elga_pkg::F_ALIGN;
                    end
                end
            end
            elga_pkg::F_ALIGN:
            begin
                if (d_reg >= 8'd27)
                begin
                    mb_next = {26'd0, (mb_reg != 27'd0)};
                end
                else
                begin
                    mb_next = (mb_reg >> d_reg[4:0])
                            | {26'd0, ((mb_reg & mask) != 27'd0)};
                end
                st_next = elga_pkg::F_ADD;
            end
            elga_pkg::F_ADD:
            begin
                if (sum[27])
                begin
                    ma_next = sum[27:1] | {26'd0, sum[0]};
                    e_next  = e_reg + 10'd1;
                end
                else
                begin
                    ma_next = sum[26:0];
                end
                st_next = elga_pkg::F_NORM;
            end
            elga_pkg::F_NORM:
            begin
                // one bit per cycle, stops at the denormal floor
                if (!ma_reg[26] && (e_reg > 10'd1) && (ma_reg != 27'd0))
                begin
                    ma_next = {ma_reg[25:0], 1'b0};
                    e_next  = e_reg - 10'd1;
                end
                else
                begin
                    st_next = elga_pkg::F_ROUND;
                end
            end
            elga_pkg::F_ROUND:
            begin
                if (ma_reg == 27'd0)
                begin
                    out_next = {sign_reg && !sub_reg, 31'd0};
                end
                else
                begin
                    if (mant[24])
                    begin
                        ef = e_reg + 10'd1;
                    end
                    else
                    begin
                        ef = mant[23] ? e_reg : 10'd0;
                    end
                    if (ef >= 10'd255)
                    begin
                        out_next = {sign_reg, 8'hFF, 23'd0};
                    end
                    else if (mant[24])
                    begin
                        out_next = {sign_reg, ef[7:0], mant[23:1]};
                    end
                    else
                    begin
                        out_next = {sign_reg, ef[7:0], mant[22:0]};
                    end
                end
                st_next = elga_pkg::F_DONE;
            end
            elga_pkg::F_DONE:
            begin
                st_next = elga_pkg::F_IDLE;
            end
            default:
            begin
                st_next = elga_pkg::F_IDLE;
            end
        endcase
    end

endmodule

@@ sv/embedding_lookup_grad_accumulate.sv @@
// Top level: embedding weight/gradient tables with lookup and gradient add.
//
// After reset the block sweeps the gradient table to zero, one word per
// cycle, over all MAX_ROWS*MAX_DIM words (65536 at the default size); busy
// stays high meanwhile, configuration writes are taken at any time. A
// request is taken when start is high and busy is low. Single-word requests
// (load, read, errors, padding skip) return one result. A lookup reads the
// weight RAM one word per cycle and returns eff_dim results on consecutive
// cycles. A gradient add is a read of the gradient RAM, then the float
// adder, then a write back. Results appear for one cycle on result with
// result_valid high; the receiver cannot stall. Unknown opcodes give no
// result. Weight words never loaded read back as undefined.
module embedding_lookup_grad_accumulate (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  elga_pkg::req_t   request,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    output logic             result_valid,
    output elga_pkg::res_t   result
);

    elga_pkg::state_t state_reg, state_next;
    elga_pkg::req_t   req_reg;

    // configuration
    logic [10:0] rows_reg;
    logic [6:0]  dim_reg;
    logic        pad_en_reg;
    logic [9:0]  pad_row_reg;

    logic [elga_pkg::ADDR_W-1:0] clr_reg, clr_next;
    logic [elga_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        pend_reg, pend_next;
    logic [elga_pkg::COL_W-1:0]  pos_reg, pos_next;
    logic                        res_valid_reg, res_valid_next;
    elga_pkg::res_t              res_reg, res_next;

    // decode
    logic [elga_pkg::RCMP_W-1:0] eff_rows;
    logic [6:0]                  eff_dim;
    logic                        row_ok, col_ok, pad_hit;
    logic [elga_pkg::ADDR_W-1:0] word_addr;
    logic [elga_pkg::ROW_W-1:0]  row_bits;

    // memories
    logic                        w_we, g_we;
    logic [elga_pkg::ADDR_W-1:0] w_addr, g_addr;
    logic [31:0]                 w_wdata, g_wdata, w_rdata, g_rdata;

    elga_pkg::fadd_req_t fa_req;
    elga_pkg::fadd_res_t fa_res;

    assign cfg_ready    = 1'b1;
    assign busy         = (state_reg != elga_pkg::S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= 11'd1024;
            dim_reg     <= 7'd64;
            pad_en_reg  <= 1'b0;
            pad_row_reg <= 10'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                elga_pkg::CFG_ROWS:    rows_reg    <= cfg_data[10:0];
                elga_pkg::CFG_DIM:     dim_reg     <= cfg_data[6:0];
                elga_pkg::CFG_PAD_EN:  pad_en_reg  <= cfg_data[0];
                elga_pkg::CFG_PAD_ROW: pad_row_reg <= cfg_data[9:0];
                default:               rows_reg    <= rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= elga_pkg::S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        pos_reg <= pos_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        eff_rows = ({6'd0, rows_reg} > elga_pkg::RCMP_W'(elga_pkg::MAX_ROWS))
                 ? elga_pkg::RCMP_W'(elga_pkg::MAX_ROWS)
                 : {6'd0, rows_reg};
        eff_dim  = (dim_reg == 7'd0) ? 7'd1 : dim_reg;
        if (eff_dim > 7'(elga_pkg::MAX_DIM))
        begin
            eff_dim = 7'(elga_pkg::MAX_DIM);
        end
        row_ok    = !req_reg.row_index[15]
                  && ({2'b00, req_reg.row_index[14:0]} < eff_rows);
        col_ok    = {1'b0, req_reg.column} < eff_dim;
        pad_hit   = pad_en_reg && ({6'd0, pad_row_reg} == req_reg.row_index);
        row_bits  = req_reg.row_index[elga_pkg::ROW_W-1:0];
        word_addr = {row_bits, req_reg.column[elga_pkg::COL_W-1:0]};
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pos_next       = pos_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        w_we    = 1'b0;
        w_addr  = word_addr;
        w_wdata = req_reg.value_bits;
        g_we    = 1'b0;
        g_addr  = word_addr;
        g_wdata = fa_res.sum;
        fa_req.start = 1'b0;
        fa_req.a     = g_rdata;
        fa_req.b     = req_reg.value_bits;

        unique case (state_reg)
            elga_pkg::S_CLEAR:
            begin
                g_we     = 1'b1;
                g_addr   = clr_reg;
                g_wdata  = 32'd0;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = elga_pkg::S_IDLE;
                end
            end
            elga_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = elga_pkg::S_DECODE;
                end
            end
            elga_pkg::S_DECODE:
            begin
                res_next.data_bits   = 32'd0;
                res_next.element_pos = req_reg.column;
                res_next.last        = 1'b1;
                res_next.status      = elga_pkg::ST_OK;
                state_next           = elga_pkg::S_IDLE;
                if (req_reg.opcode > elga_pkg::OP_READ_G)
                begin
                    // unknown opcode: silently dropped
                end
                else if (req_reg.opcode == elga_pkg::OP_LOOKUP)
                begin
                    if (!row_ok)
                    begin
                        res_next.element_pos = 6'd0;
                        res_next.status      = elga_pkg::ST_RANGE;
                        res_valid_next       = 1'b1;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = elga_pkg::S_LOOKUP;
                    end
                end
                else if (!row_ok || !col_ok)
                begin
                    res_next.status = elga_pkg::ST_RANGE;
                    res_valid_next  = 1'b1;
                end
                else
                begin
                    case (req_reg.opcode)
                        elga_pkg::OP_LOAD_W:
                        begin
                            w_we           = 1'b1;
                            res_valid_next = 1'b1;
                        end
                        elga_pkg::OP_ACC_G:
                        begin
                            if (pad_hit)
                            begin
                                res_next.status = elga_pkg::ST_PAD;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = elga_pkg::S_GRAD_RD;
                            end
                        end
                        default:
                        begin
                            state_next = elga_pkg::S_RD_WAIT;
                        end
                    endcase
                end
            end
            elga_pkg::S_RD_WAIT:
            begin
                res_next.data_bits = (req_reg.opcode == elga_pkg::OP_READ_W)
                                   ? w_rdata : g_rdata;
                res_valid_next     = 1'b1;
                state_next         = elga_pkg::S_IDLE;
            end
            elga_pkg::S_LOOKUP:
            begin
                // issue one read per cycle, emit the word read in the previous cycle
                w_addr = {row_bits, cnt_reg[elga_pkg::COL_W-1:0]};
                if ({1'b0, cnt_reg} < {1'b0, eff_dim[elga_pkg::CNT_W-1:0]})
                begin
                    pend_next = 1'b1;
                    pos_next  = cnt_reg[elga_pkg::COL_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    res_next.data_bits   = w_rdata;
                    res_next.element_pos = 6'(pos_reg);
                    res_next.last        = ({1'b0, pos_reg} + 1'b1)
                                         == eff_dim[elga_pkg::CNT_W-1:0];
                    res_next.status      = elga_pkg::ST_OK;
                    res_valid_next       = 1'b1;
                    if (res_next.last)
                    begin
                        pend_next  = 1'b0;
                        state_next = elga_pkg::S_IDLE;
                    end
                end
            end
            elga_pkg::S_GRAD_RD:
            begin
                fa_req.start = 1'b1;
                state_next   = elga_pkg::S_FP_WAIT;
            end
            elga_pkg::S_FP_WAIT:
            begin
                if (fa_res.done)
                begin
                    g_we           = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = elga_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = elga_pkg::S_IDLE;
            end
        endcase
    end

    elga_ram #(
        .WIDTH (32),
        .DEPTH (elga_pkg::DEPTH)
    ) u_wram (
        .clk   (clk),
        .we    (w_we),
        .addr  (w_addr),
        .wdata (w_wdata),
        .rdata (w_rdata)
    );

    elga_ram #(
        .WIDTH (32),
        .DEPTH (elga_pkg::DEPTH)
    ) u_gram (
        .clk   (clk),
        .we    (g_we),
        .addr  (g_addr),
        .wdata (g_wdata),
        .rdata (g_rdata)
    );

    elga_fadd u_fadd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fa_req),
        .res   (fa_res)
    );

`ifndef ASSERT_OFF
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == elga_pkg::S_CLEAR) |-> !res_valid_reg)
        else $error("result during clear sweep");
    a_grad_write_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        (g_we && (state_reg != elga_pkg::S_CLEAR)) |-> fa_res.done)
        else $error("gradient write without adder result");
    a_lookup_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && (state_reg == elga_pkg::S_LOOKUP)) |-> (cnt_reg != '0))
        else $error("lookup pending without issued read");
    a_fadd_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fa_req.start |=> !fa_res.done || $past(state_reg == elga_pkg::S_GRAD_RD))
        else $error("adder start out of sequence");
`endif

endmodule
